FILE: sv/breakpoint_envelope_interpolator_assert.svh
// Assertion macros shared by the breakpoint envelope RTL.
`ifndef BREAKPOINT_ENVELOPE_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_ENVELOPE_INTERPOLATOR_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define BEI_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BEI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BEI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bei_pkg.sv
// Package: widths, codes and reset constants of the breakpoint envelope.
`default_nettype none
package bei_pkg;
	localparam int BEAT_W         = 32;
	localparam int VAL_W          = 24;
	localparam int PTS_W          = 5;
	localparam int FRAC_W         = 16;
	localparam int MAX_POINTS_DEF = 16;

	// restoring divide gives FRAC_W fraction bits plus the 1.0 bit
	localparam int DIV_STEPS = FRAC_W + 1;
	// fraction (unsigned, with sign bit) times value difference
	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = DIV_STEPS + 1 + DIFF_W;

	localparam logic signed [VAL_W-1:0] EMPTY_RESET = 24'sd65536;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;
endpackage
`default_nettype wire

FILE: sv/breakpoint_envelope_interpolator.sv
// Insert: points above the new beat shift up one entry, then it is written in place.
// Query: scan one entry a cycle, then a 17-step restoring divide; clamped queries skip it.
// Rejected insert or query on an empty table goes straight to the result.
// One request in flight; the next is accepted the cycle after the result is staged.
// The shared 34-bit subtractor does every compare, width, offset, difference and divide step.
// Async reset empties the table, sets empty_value to 1.0 and clears the output valid.
`default_nettype none
module breakpoint_envelope_interpolator
	import bei_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    cfg_we,
	input  wire logic signed [VAL_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                    request_valid,
	output logic                         request_stall,
	input  wire logic                    operation,
	input  wire logic [BEAT_W-1:0]       beat_position,
	input  wire logic signed [VAL_W-1:0] point_value,
	// result channel
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output logic signed [VAL_W-1:0]      result_value,
	output logic                         insert_rejected,
	output logic [PTS_W-1:0]             points_stored
);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int SW   = $clog2(DIV_STEPS);
	localparam int ALUW = BEAT_W + 1;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_INS_CMP = 12'b0000_0000_0010,
		S_INS_WR  = 12'b0000_0000_0100,
		S_Q_LAST  = 12'b0000_0000_1000,
		S_Q_SCAN  = 12'b0000_0001_0000,
		S_Q_WID   = 12'b0000_0010_0000,
		S_Q_OFS   = 12'b0000_0100_0000,
		S_Q_DIF   = 12'b0000_1000_0000,
		S_DIV     = 12'b0001_0000_0000,
		S_MUL     = 12'b0010_0000_0000,
		S_ADD     = 12'b0100_0000_0000,
		S_DONE    = 12'b1000_0000_0000
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic signed [VAL_W-1:0]   empty_q;
	logic [BEAT_W-1:0]         beat_q;
	logic signed [VAL_W-1:0]   val_q;
	logic [CW-1:0]             idx_q;
	logic [BEAT_W-1:0]         b0_q, b1_q, w_q;
	logic signed [VAL_W-1:0]   v0_q, v1_q;
	logic                      last_hit_q;
	logic [ALUW-1:0]           rem_q;
	logic [DIV_STEPS-1:0]      quo_q;
	logic [SW-1:0]             step_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [VAL_W-1:0]   res_val_q;
	logic                      res_rej_q;
	logic                      result_valid_q;
	logic signed [VAL_W-1:0]   result_value_q;
	logic                      insert_rejected_q;
	logic [PTS_W-1:0]          points_stored_q;

	logic                      accept;
	logic                      full;
	logic                      out_load;
	logic [CW-1:0]             cnt_m1, idx_m2, idx_p1;
	logic                      ram_we;
	logic [AW-1:0]             ram_raddr;
	logic [BEAT_W-1:0]         beat_wdata, beat_rdata;
	logic [VAL_W-1:0]          val_wdata, val_rdata;
	logic signed [VAL_W-1:0]   rval;
	logic [ALUW-1:0]           alu_a, alu_b;
	logic [ALUW:0]             alu_diff;
	logic                      alu_lt;
	logic signed [PROD_W-1:0]  prod_sh;

	assign request_stall = (state_q != S_IDLE);
	assign accept        = request_valid && !request_stall;
	assign full          = (count_q >= CW'(MAX_POINTS));
	assign out_load      = (state_q == S_DONE) && (!result_valid_q || !result_stall);
	assign cnt_m1        = count_q - CW'(1);
	assign idx_m2        = idx_q - CW'(2);
	assign idx_p1        = idx_q + CW'(1);
	assign rval          = $signed(val_rdata);
	assign prod_sh       = prod_q >>> FRAC_W;

	assign result_valid    = result_valid_q;
	assign result_value    = result_value_q;
	assign insert_rejected = insert_rejected_q;
	assign points_stored   = points_stored_q;

	// read address: next entry the sequencer looks at
	always_comb begin
		unique case (state_q)
			S_IDLE:    ram_raddr = cnt_m1[AW-1:0];
			S_INS_CMP: ram_raddr = idx_m2[AW-1:0];
			S_Q_SCAN:  ram_raddr = idx_p1[AW-1:0];
			default:   ram_raddr = '0;
		endcase
	end

	// write port: shift one entry up, or drop the new point in place
	always_comb begin
		ram_we     = 1'b0;
		beat_wdata = beat_q;
		val_wdata  = val_q;
		if (state_q == S_INS_CMP) begin
			ram_we     = alu_lt;
			beat_wdata = beat_rdata;
			val_wdata  = val_rdata;
		end else if (state_q == S_INS_WR) begin
			ram_we = 1'b1;
		end
	end

	bei_ram #(.WIDTH(BEAT_W), .DEPTH(MAX_POINTS)) u_beat_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (beat_wdata),
		.raddr (ram_raddr),
		.rdata (beat_rdata)
	);

	bei_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_val_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (val_wdata),
		.raddr (ram_raddr),
		.rdata (val_rdata)
	);

	// shared subtractor operands
	always_comb begin
		unique case (state_q)
			S_INS_CMP, S_Q_LAST: begin
				alu_a = {1'b0, beat_q};
				alu_b = {1'b0, beat_rdata};
			end
			S_Q_SCAN: begin
				alu_a = {1'b0, beat_rdata};
				alu_b = {1'b0, beat_q};
			end
			S_Q_WID: begin
				alu_a = {1'b0, b1_q};
				alu_b = {1'b0, b0_q};
			end
			S_Q_OFS: begin
				alu_a = {1'b0, beat_q};
				alu_b = {1'b0, b0_q};
			end
			S_Q_DIF: begin
				alu_a = {{(ALUW - VAL_W){v1_q[VAL_W-1]}}, v1_q};
				alu_b = {{(ALUW - VAL_W){v0_q[VAL_W-1]}}, v0_q};
			end
			S_DIV: begin
				alu_a = rem_q;
				alu_b = {1'b0, w_q};
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_lt   = alu_diff[ALUW];

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			empty_q        <= EMPTY_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				empty_q <= cfg_wdata;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_INSERT) begin
							if (full) begin
								state_q <= S_DONE;
							end else if (count_q == '0) begin
								state_q <= S_INS_WR;
							end else begin
								state_q <= S_INS_CMP;
							end
						end else begin
							state_q <= (count_q == '0) ? S_DONE : S_Q_LAST;
						end
					end
				end
				S_INS_CMP: begin
					if (!alu_lt || idx_q == CW'(1)) begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				// the first point is always checked: it wins when every beat ties
				S_Q_LAST: state_q <= S_Q_SCAN;
				S_Q_SCAN: begin
					if (!alu_lt) begin
						state_q <= (idx_q == '0) ? S_DONE : S_Q_WID;
					end else if (last_hit_q) begin
						state_q <= S_DONE;
					end
				end
				S_Q_WID: state_q <= S_Q_OFS;
				S_Q_OFS: state_q <= (w_q == '0) ? S_DONE : S_Q_DIF;
				S_Q_DIF: state_q <= S_DIV;
				S_DIV: begin
					if (step_q == SW'(DIV_STEPS - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			result_value_q    <= res_val_q;
			insert_rejected_q <= res_rej_q;
			points_stored_q   <= PTS_W'(count_q);
		end
		unique case (state_q)
			S_IDLE: begin
				beat_q    <= beat_position;
				val_q     <= point_value;
				idx_q     <= count_q;
				res_rej_q <= (operation == OP_INSERT) && full;
				res_val_q <= ((operation == OP_QUERY) && count_q == '0) ? empty_q : '0;
			end
			S_INS_CMP: begin
				if (alu_lt) begin
					idx_q <= idx_q - CW'(1);
				end
			end
			// at or past the last point: keep its value unless the first point ties
			S_Q_LAST: begin
				res_val_q  <= rval;
				idx_q      <= '0;
				last_hit_q <= !alu_lt;
			end
			S_Q_SCAN: begin
				if (!alu_lt) begin
					res_val_q <= rval;
					b1_q      <= beat_rdata;
					v1_q      <= rval;
				end else begin
					b0_q  <= beat_rdata;
					v0_q  <= rval;
					idx_q <= idx_p1;
				end
			end
			S_Q_WID: w_q <= alu_diff[BEAT_W-1:0];
			S_Q_OFS: begin
				res_val_q <= v0_q;
				rem_q     <= alu_diff[ALUW-1:0];
				quo_q     <= '0;
				step_q    <= '0;
			end
			S_Q_DIF: diff_q <= alu_diff[DIFF_W-1:0];
			// one restoring divide step per cycle
			S_DIV: begin
				quo_q  <= {quo_q[DIV_STEPS-2:0], !alu_lt};
				rem_q  <= alu_lt ? {rem_q[BEAT_W-1:0], 1'b0}
				                 : {alu_diff[BEAT_W-1:0], 1'b0};
				step_q <= step_q + SW'(1);
			end
			S_MUL: prod_q <= $signed({1'b0, quo_q}) * diff_q;
			S_ADD: res_val_q <= v0_q + $signed(prod_sh[VAL_W-1:0]);
			default: ;
		endcase
	end

	`include "breakpoint_envelope_interpolator_assert.svh"

	`BEI_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_POINTS), "point count above table size")
	`BEI_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted request left sequencer idle")
	`BEI_ASSERT_IMPLY(a_div_width, state_q == S_DIV, w_q != '0, "divide started on zero-width interval")
	`BEI_ASSERT_IMPLY(a_reject_full, result_valid_q && insert_rejected_q, count_q == CW'(MAX_POINTS), "insert rejected while table not full")
	`BEI_ASSERT_NEXT(a_insert_count, state_q == S_INS_WR, count_q == $past(count_q) + CW'(1), "insert did not bump point count")
endmodule
`default_nettype wire

FILE: sv/bei_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bei_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
